// ===== design/cic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cic_pkg - shared types and constants of the CABAC context store
// Entry layout, word codes, register indexes and the H.264 (m,n) init ROM
// for context indexes 0..23.
// ----------------------------------------------------------------------------
package cic_pkg;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SIZE_W     = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_QP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SELECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTRA_SLICE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CTX      = 2'd3;

  localparam logic [1:0] INTRA_COLUMN  = 2'd3;
  localparam logic [1:0] TABLE_INVALID = 2'd3;
  localparam logic [5:0] QP_MAX        = 6'd51;
  localparam int         ROM_ROWS      = 24;
  localparam int         PRE_MIN       = 1;
  localparam int         PRE_MAX       = 126;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } cic_mode_e;

  typedef struct packed {
    logic       valid;
    logic       mps;
    logic [5:0] state;
  } ctx_entry_t;

  typedef struct packed {
    logic              ok;
    logic signed [7:0] m;
    logic signed [7:0] n;
  } rom_cell_t;

  // Rows 0..10 are shared by all columns; rows 11..23 have no intra entry.
  function automatic rom_cell_t cic_rom(input logic [4:0] row, input logic [1:0] col);
    logic signed [7:0] m0, m1, m2, n0, n1, n2;
    logic              shared;
    logic              known;
    rom_cell_t         res;
    m0 = '0; m1 = '0; m2 = '0;
    n0 = '0; n1 = '0; n2 = '0;
    shared = 1'b0;
    known  = 1'b1;
    case (row)
      5'd0:  begin m0 = 8'sd20;  n0 = -8'sd15; shared = 1'b1; end
      5'd1:  begin m0 = 8'sd2;   n0 = 8'sd54;  shared = 1'b1; end
      5'd2:  begin m0 = 8'sd3;   n0 = 8'sd74;  shared = 1'b1; end
      5'd3:  begin m0 = 8'sd20;  n0 = -8'sd15; shared = 1'b1; end
      5'd4:  begin m0 = 8'sd2;   n0 = 8'sd54;  shared = 1'b1; end
      5'd5:  begin m0 = 8'sd3;   n0 = 8'sd74;  shared = 1'b1; end
      5'd6:  begin m0 = -8'sd28; n0 = 8'sd127; shared = 1'b1; end
      5'd7:  begin m0 = -8'sd23; n0 = 8'sd104; shared = 1'b1; end
      5'd8:  begin m0 = -8'sd6;  n0 = 8'sd53;  shared = 1'b1; end
      5'd9:  begin m0 = -8'sd1;  n0 = 8'sd54;  shared = 1'b1; end
      5'd10: begin m0 = 8'sd7;   n0 = 8'sd51;  shared = 1'b1; end
      5'd11: begin
        m0 = 8'sd23; n0 = 8'sd33; m1 = 8'sd22; n1 = 8'sd25; m2 = 8'sd29; n2 = 8'sd16;
      end
      5'd12: begin
        m0 = 8'sd23; n0 = 8'sd2; m1 = 8'sd34; n1 = 8'sd0; m2 = 8'sd25; n2 = 8'sd0;
      end
      5'd13: begin
        m0 = 8'sd21; n0 = 8'sd0; m1 = 8'sd16; n1 = 8'sd0; m2 = 8'sd14; n2 = 8'sd0;
      end
      5'd14: begin
        m0 = 8'sd1; n0 = 8'sd9; m1 = -8'sd2; n1 = 8'sd9; m2 = -8'sd10; n2 = 8'sd51;
      end
      5'd15: begin
        m0 = 8'sd0; n0 = 8'sd49; m1 = 8'sd4; n1 = 8'sd41; m2 = -8'sd3; n2 = 8'sd62;
      end
      5'd16: begin
        m0 = -8'sd37; n0 = 8'sd118; m1 = -8'sd29; n1 = 8'sd118; m2 = -8'sd27; n2 = 8'sd99;
      end
      5'd17: begin
        m0 = 8'sd5; n0 = 8'sd57; m1 = 8'sd2; n1 = 8'sd65; m2 = 8'sd26; n2 = 8'sd16;
      end
      5'd18: begin
        m0 = -8'sd13; n0 = 8'sd78; m1 = -8'sd6; n1 = 8'sd71; m2 = -8'sd4; n2 = 8'sd85;
      end
      5'd19: begin
        m0 = -8'sd11; n0 = 8'sd65; m1 = -8'sd13; n1 = 8'sd79; m2 = -8'sd24; n2 = 8'sd102;
      end
      5'd20: begin
        m0 = 8'sd1; n0 = 8'sd62; m1 = 8'sd5; n1 = 8'sd52; m2 = 8'sd5; n2 = 8'sd57;
      end
      5'd21: begin
        m0 = 8'sd12; n0 = 8'sd49; m1 = 8'sd9; n1 = 8'sd50; m2 = 8'sd6; n2 = 8'sd57;
      end
      5'd22: begin
        m0 = -8'sd4; n0 = 8'sd73; m1 = -8'sd3; n1 = 8'sd70; m2 = -8'sd17; n2 = 8'sd73;
      end
      5'd23: begin
        m0 = 8'sd17; n0 = 8'sd50; m1 = 8'sd10; n1 = 8'sd54; m2 = 8'sd14; n2 = 8'sd57;
      end
      default: known = 1'b0;
    endcase
    if (shared) begin
      m1 = m0; m2 = m0;
      n1 = n0; n2 = n0;
    end
    case (col)
      2'd0:    res = '{ok: known,  m: m0, n: n0};
      2'd1:    res = '{ok: known,  m: m1, n: n1};
      2'd2:    res = '{ok: known,  m: m2, n: n2};
      default: res = '{ok: shared, m: m0, n: n0};
    endcase
    return res;
  endfunction

endpackage

// ===== design/cic_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cic_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ----------------------------------------------------------------------------
module cic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cabac_context_init_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabac_context_init_store - H.264 CABAC context-model store
// Context entries (state, MPS, initialized) live in one RAM. Init words
// sweep the active set, writing ROM-derived values or zeros; read and write
// words access one entry.
//
//   channel  | dir | handshake          | payload
//   s_axis   | in  | tvalid/tready      | tdata: ctx_index, new_state, new_mps
//            |     |                    | tuser: mode
//   m_axis   | out | tvalid/tready      | tdata: state_index, mps_value,
//            |     |                    |   is_initialized, in_range, active_size
//   cfg      | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// An in-range read goes through the registered RAM read and the read state;
// write, out-of-range and unused-mode words load the result directly. Init
// makes one RAM write per entry. One word is in flight at a time; a new
// word is taken while the result register drains. Entries at or above the
// active size are never observed, so no clearing pass follows reset. A
// stalled m_axis holds the result and blocks further words.
// ----------------------------------------------------------------------------
module cabac_context_init_store #(
  parameter int unsigned MODEL_COUNT      = 1024,
  parameter int unsigned COVERED_CONTEXTS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cic_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // ctx_index, new_state, new_mps
  input  logic [cic_pkg::IN_USER_W-1:0]       s_axis_tuser,  // mode
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cic_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // state_index, mps_value,
                                                             // is_initialized, in_range,
                                                             // active_size
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cic_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [cic_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import cic_pkg::*;

  localparam int unsigned AW = $clog2(MODEL_COUNT);
  localparam int unsigned SW = $clog2(MODEL_COUNT + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  // configuration
  logic signed [6:0]  slice_qp_q;
  logic [1:0]         table_sel_q;
  logic               intra_q;
  logic signed [10:0] max_ctx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_qp_q  <= '0;
      table_sel_q <= '0;
      intra_q     <= 1'b0;
      max_ctx_q   <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SLICE_QP:     slice_qp_q  <= cfg_data_i[6:0];
        CFG_TABLE_SELECT: table_sel_q <= cfg_data_i[1:0];
        CFG_INTRA_SLICE:  intra_q     <= cfg_data_i[0];
        CFG_MAX_CTX:      max_ctx_q   <= cfg_data_i[10:0];
        default:          ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // input fields
  logic [1:0] in_mode;
  logic [9:0] in_idx;
  logic [5:0] in_state;
  logic       in_mps;

  assign in_mode  = s_axis_tuser[1:0];
  assign in_idx   = s_axis_tdata[9:0];
  assign in_state = s_axis_tdata[15:10];
  assign in_mps   = s_axis_tdata[16];

  // control state
  logic [1:0]    state_q, state_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] size_q, size_d;
  logic          out_valid_q, out_valid_d;
  ctx_entry_t    out_entry_q, out_entry_d;
  logic          out_inr_q, out_inr_d;
  logic [SW-1:0] out_size_q;
  logic          out_load;

  logic          s_accept;
  logic          inr;
  logic [SW-1:0] size_new;
  logic [11:0]   size_plus;

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign inr           = {1'b0, in_idx} < SIZE_W'(size_q);

  assign size_plus = {1'b0, max_ctx_q} + 12'd1;
  always_comb begin
    if (max_ctx_q[10]) begin
      size_new = '0;
    end else if (size_plus > 12'(MODEL_COUNT)) begin
      size_new = SW'(MODEL_COUNT);
    end else begin
      size_new = SW'(size_plus);
    end
  end

  // init value for the swept entry
  logic [5:0]         qp_c;
  logic [1:0]         col;
  logic               col_ok;
  rom_cell_t          rom_entry;
  logic signed [7:0]  qp_s;
  logic signed [15:0] prod;
  logic signed [15:0] pre;
  logic [6:0]         pre_c;
  ctx_entry_t         init_entry;

  always_comb begin
    if (slice_qp_q < 0) begin
      qp_c = '0;
    end else if (slice_qp_q > $signed({1'b0, QP_MAX})) begin
      qp_c = QP_MAX;
    end else begin
      qp_c = slice_qp_q[5:0];
    end
  end

  assign col       = intra_q ? INTRA_COLUMN : table_sel_q;
  assign col_ok    = intra_q || (table_sel_q != TABLE_INVALID);
  assign rom_entry = cic_rom(cnt_q[4:0], col);
  assign qp_s      = $signed({2'b00, qp_c});
  assign prod      = rom_entry.m * qp_s;
  assign pre       = (prod >>> 4) + $signed({{8{rom_entry.n[7]}}, rom_entry.n});

  always_comb begin
    if (pre < 16'(PRE_MIN)) begin
      pre_c = 7'(PRE_MIN);
    end else if (pre > 16'(PRE_MAX)) begin
      pre_c = 7'(PRE_MAX);
    end else begin
      pre_c = pre[6:0];
    end
    if (rom_entry.ok && col_ok && (cnt_q < SW'(COVERED_CONTEXTS)) &&
        (cnt_q < SW'(ROM_ROWS))) begin
      init_entry.valid = 1'b1;
      if (pre_c <= 7'd63) begin
        init_entry.mps   = 1'b0;
        init_entry.state = 6'(7'd63 - pre_c);
      end else begin
        init_entry.mps   = 1'b1;
        init_entry.state = 6'(pre_c - 7'd64);
      end
    end else begin
      init_entry = '0;
    end
  end

  // RAM
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  ctx_entry_t    ram_wdata, ram_rdata;

  cic_ram #(
    .WIDTH($bits(ctx_entry_t)),
    .DEPTH(MODEL_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(in_idx[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    size_d      = size_q;
    out_load    = 1'b0;
    out_entry_d = '0;
    out_inr_d   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = in_idx[AW-1:0];
    ram_wdata   = '{valid: 1'b1, mps: in_mps, state: in_state};
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          case (in_mode)
            MODE_INIT: begin
              size_d = size_new;
              cnt_d  = '0;
              if (size_new == '0) begin
                out_load = 1'b1;
              end else begin
                state_d = ST_SWEEP;
              end
            end
            MODE_READ: begin
              if (inr) begin
                ram_re  = 1'b1;
                state_d = ST_READ;
              end else begin
                out_load = 1'b1;
              end
            end
            MODE_WRITE: begin
              out_load = 1'b1;
              if (inr) begin
                ram_we      = 1'b1;
                out_entry_d = ram_wdata;
                out_inr_d   = 1'b1;
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        out_load    = 1'b1;
        out_entry_d = ram_rdata;
        out_inr_d   = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = init_entry;
        cnt_d     = SW'(cnt_q + SW'(1));
        if (SW'(cnt_q + SW'(1)) == size_q) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = out_load || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      size_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_entry_q <= out_entry_d;
      out_inr_q   <= out_inr_d;
      out_size_q  <= size_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, SIZE_W'(out_size_q), out_inr_q, out_entry_q.valid,
                          out_entry_q.mps, out_entry_q.state};

  // checks
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (cnt_q < size_q))
    else $error("sweep counter beyond active size");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && !m_axis_tready))
    else $error("result register overwritten while stalled");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (out_valid_q && out_inr_q && state_q == ST_IDLE))
    else $error("read did not produce a result");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (SW'(ram_waddr) < size_d))
    else $error("RAM write outside active set");

  a_size_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= SW'(MODEL_COUNT))
    else $error("active size above capacity");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the CABAC context-model store
// Drives init, read, write and unused-mode words on s_axis and slice settings on the cfg
// channel. Each accepted word is run through a local model of the store
// (H.264 m,n init per slice QP and table) and the m_axis words are checked
// in order. A directed table opens the run; random phases with changing
// settings and stall patterns follow, including a long m_axis hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import cic_pkg::*;

  localparam int          STORE_DEPTH  = 1024;
  localparam int          COVERED      = 24;
  localparam int          INTRA_ROWS   = 11;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam int          PHASE_COUNT  = 6;
  localparam int          PHASE_WORDS  = 72;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER [4] =
    '{CFG_SLICE_QP, CFG_TABLE_SELECT, CFG_INTRA_SLICE, CFG_MAX_CTX};

  // m0, n0, m1, n1, m2, n2 per context; intra uses column 0 for rows 0..10
  localparam int INIT_MN [COVERED][6] = '{
    '{ 20, -15,  20, -15,  20, -15},
    '{  2,  54,   2,  54,   2,  54},
    '{  3,  74,   3,  74,   3,  74},
    '{ 20, -15,  20, -15,  20, -15},
    '{  2,  54,   2,  54,   2,  54},
    '{  3,  74,   3,  74,   3,  74},
    '{-28, 127, -28, 127, -28, 127},
    '{-23, 104, -23, 104, -23, 104},
    '{ -6,  53,  -6,  53,  -6,  53},
    '{ -1,  54,  -1,  54,  -1,  54},
    '{  7,  51,   7,  51,   7,  51},
    '{ 23,  33,  22,  25,  29,  16},
    '{ 23,   2,  34,   0,  25,   0},
    '{ 21,   0,  16,   0,  14,   0},
    '{  1,   9,  -2,   9, -10,  51},
    '{  0,  49,   4,  41,  -3,  62},
    '{-37, 118, -29, 118, -27,  99},
    '{  5,  57,   2,  65,  26,  16},
    '{-13,  78,  -6,  71,  -4,  85},
    '{-11,  65, -13,  79, -24, 102},
    '{  1,  62,   5,  52,   5,  57},
    '{ 12,  49,   9,  50,   6,  57},
    '{ -4,  73,  -3,  70, -17,  73},
    '{ 17,  50,  10,  54,  14,  57}
  };

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              inr;
    logic              init;
    logic              mps;
    logic [5:0]        state;
  } ctx_result_t;

  typedef struct {
    bit          cfg_row;
    bit          typed;
    int          qp, tsel, intra, maxc;
    logic [1:0]  mode;
    logic [9:0]  idx;
    logic [5:0]  st;
    logic        nm;
    ctx_result_t want;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;  // ctx_index, new_state, new_mps
  logic [IN_USER_W-1:0]   s_axis_tuser;  // mode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;  // state_index, mps_value, is_initialized,
                                         // in_range, active_size
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  cabac_context_init_store uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // local copy of the store and its settings
  logic [5:0]  ctx_state [STORE_DEPTH];
  logic        ctx_mps   [STORE_DEPTH];
  logic        ctx_valid [STORE_DEPTH];
  int          cur_size;
  int          slice_qp_reg, table_sel_reg, intra_reg, max_ctx_reg;

  ctx_result_t pending_results [$];
  stim_row_t   directed_rows [$];
  int          bad_results;
  int          tx_idle_pct, rx_idle_pct;
  int          long_hold_req, hold_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void clear_store();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      ctx_state[i] = '0;
      ctx_mps[i]   = 1'b0;
      ctx_valid[i] = 1'b0;
    end
  endfunction

  function automatic void apply_slice_init();
    int col, qp, pre, count, m, n;
    clear_store();
    if (max_ctx_reg < 0) begin
      cur_size = 0;
      return;
    end
    cur_size = (max_ctx_reg + 1 > STORE_DEPTH) ? STORE_DEPTH : max_ctx_reg + 1;
    if (intra_reg != 0) col = INTRA_COLUMN;
    else if (table_sel_reg != TABLE_INVALID) col = table_sel_reg;
    else return;
    qp = slice_qp_reg < 0 ? 0 : (slice_qp_reg > QP_MAX ? QP_MAX : slice_qp_reg);
    count = cur_size < COVERED ? cur_size : COVERED;
    for (int i = 0; i < count; i++) begin
      if (col == INTRA_COLUMN && i >= INTRA_ROWS) continue;
      m = INIT_MN[i][(col == INTRA_COLUMN) ? 0 : 2 * col];
      n = INIT_MN[i][(col == INTRA_COLUMN) ? 1 : 2 * col + 1];
      pre = ((m * qp) >>> 4) + n;
      if (pre < PRE_MIN) pre = PRE_MIN;
      if (pre > PRE_MAX) pre = PRE_MAX;
      if (pre <= 63) begin
        ctx_state[i] = 6'(63 - pre);
        ctx_mps[i]   = 1'b0;
      end else begin
        ctx_state[i] = 6'(pre - 64);
        ctx_mps[i]   = 1'b1;
      end
      ctx_valid[i] = 1'b1;
    end
  endfunction

  function automatic ctx_result_t predict_context_result(logic [1:0] mode, logic [9:0] idx,
                                                         logic [5:0] st, logic nm);
    ctx_result_t r;
    r = '0;
    if (mode == MODE_INIT) begin
      apply_slice_init();
    end else if ((mode == MODE_READ || mode == MODE_WRITE) && int'(idx) < cur_size) begin
      if (mode == MODE_WRITE) begin
        ctx_state[idx] = st;
        ctx_mps[idx]   = nm;
        ctx_valid[idx] = 1'b1;
      end
      r.state = ctx_state[idx];
      r.mps   = ctx_mps[idx];
      r.init  = ctx_valid[idx];
      r.inr   = 1'b1;
    end
    r.size = SIZE_W'(cur_size);
    return r;
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    bad_results++;
    if (bad_results <= 10)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  function automatic void check_result(ctx_result_t got);
    ctx_result_t want;
    if (pending_results.size() == 0) begin
      note_mismatch("unexpected word, active_size", -1, got.size);
      return;
    end
    want = pending_results.pop_front();
    if (got.state != want.state) note_mismatch("state_index", want.state, got.state);
    if (got.mps   != want.mps)   note_mismatch("mps_value", want.mps, got.mps);
    if (got.init  != want.init)  note_mismatch("is_initialized", want.init, got.init);
    if (got.inr   != want.inr)   note_mismatch("in_range", want.inr, got.inr);
    if (got.size  != want.size)  note_mismatch("active_size", want.size, got.size);
  endfunction

  // m_axis side: checks, random stalls and the long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata[$bits(ctx_result_t)-1:0]);
      if (long_hold_req != 0) begin
        hold_left     = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // called right after a rising edge; returns right after the accepting edge
  task automatic offer_word(logic [1:0] mode, logic [9:0] idx, logic [5:0] st, logic nm,
                            bit typed, ctx_result_t want);
    ctx_result_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {7'd0, nm, st, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_context_result(mode, idx, st, nm);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic set_slice_config(int qp, int tsel, int intra, int maxc);
    logic [CFG_DATA_W-1:0] vals [4];
    vals[0] = CFG_DATA_W'(qp);
    vals[1] = CFG_DATA_W'(tsel);
    vals[2] = CFG_DATA_W'(intra);
    vals[3] = CFG_DATA_W'(maxc);
    for (int r = 0; r < 4; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_ORDER[r];
      cfg_data_i  <= vals[r];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i   <= 1'b0;
    slice_qp_reg  = int'($signed(vals[0][6:0]));
    table_sel_reg = int'(vals[1][1:0]);
    intra_reg     = int'(vals[2][0]);
    max_ctx_reg   = int'($signed(vals[3]));
  endtask

  function automatic void add_settings(int qp, int tsel, int intra, int maxc);
    stim_row_t row;
    row = '{default: '0};
    row.cfg_row = 1'b1;
    row.qp = qp; row.tsel = tsel; row.intra = intra; row.maxc = maxc;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_word(logic [1:0] mode, logic [9:0] idx, logic [5:0] st,
                                   logic nm);
    stim_row_t row;
    row = '{default: '0};
    row.mode = mode; row.idx = idx; row.st = st; row.nm = nm;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_known(logic [1:0] mode, logic [9:0] idx, logic [5:0] st,
                                    logic nm, logic [5:0] w_state, logic w_mps,
                                    logic w_init, logic w_inr, int w_size);
    stim_row_t row;
    row = '{default: '0};
    row.typed = 1'b1;
    row.mode = mode; row.idx = idx; row.st = st; row.nm = nm;
    row.want = '{size: SIZE_W'(w_size), inr: w_inr, init: w_init, mps: w_mps,
                 state: w_state};
    directed_rows.push_back(row);
  endfunction

  initial begin
    stim_row_t   row;
    ctx_result_t none;
    logic [1:0]  mode;
    logic [9:0]  idx;
    int          pick, qp, tsel, intra, maxc;

    none          = '0;
    bad_results   = 0;
    long_hold_req = 0;
    hold_left     = 0;
    tx_idle_pct   = 9;
    rx_idle_pct   = 88;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    clear_store();
    cur_size      = 0;
    slice_qp_reg  = 0;
    table_sel_reg = 0;
    intra_reg     = 0;
    max_ctx_reg   = -1;

    // after reset: empty set
    add_known(MODE_READ,   10'd0,    6'd0,  1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 0);
    add_known(MODE_WRITE,  10'd1023, 6'd63, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 0);
    add_known(MODE_UNUSED, 10'd5,    6'd0,  1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 0);
    add_known(MODE_INIT,   10'd0,    6'd0,  1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 0);
    // full store, top QP, table 0
    add_settings(51, 0, 0, 1023);
    add_known(MODE_INIT,   10'd0,    6'd0,  1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 1024);
    add_word(MODE_READ, 10'd0, 6'd0, 1'b0);
    add_word(MODE_READ, 10'd23, 6'd0, 1'b0);
    add_known(MODE_READ,   10'd24,   6'd0,  1'b0, 6'd0, 1'b0, 1'b0, 1'b1, 1024);
    add_known(MODE_WRITE,  10'd1023, 6'd63, 1'b1, 6'd63, 1'b1, 1'b1, 1'b1, 1024);
    add_word(MODE_READ, 10'd1023, 6'd0, 1'b0);
    add_known(MODE_UNUSED, 10'd1023, 6'd63, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 1024);
    // intra, lowest QP; rows 11 and up have no intra entry
    add_settings(-64, 0, 1, 1023);
    add_known(MODE_INIT,   10'd0,    6'd0,  1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 1024);
    add_known(MODE_READ,   10'd11,   6'd0,  1'b0, 6'd0, 1'b0, 1'b0, 1'b1, 1024);
    add_word(MODE_READ, 10'd6, 6'd0, 1'b0);
    add_word(MODE_READ, 10'd10, 6'd0, 1'b0);
    // invalid table, single entry
    add_settings(63, 3, 0, 0);
    add_known(MODE_INIT,   10'd0,    6'd0,  1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 1);
    add_known(MODE_READ,   10'd0,    6'd0,  1'b0, 6'd0, 1'b0, 1'b0, 1'b1, 1);
    add_known(MODE_READ,   10'd1,    6'd0,  1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 1);
    add_known(MODE_WRITE,  10'd0,    6'd0,  1'b0, 6'd0, 1'b0, 1'b1, 1'b1, 1);
    // set smaller than the ROM
    add_settings(0, 2, 0, 10);
    add_known(MODE_INIT,   10'd0,    6'd0,  1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 11);
    add_word(MODE_READ, 10'd10, 6'd0, 1'b0);
    add_known(MODE_READ,   10'd11,   6'd0,  1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 11);
    add_settings(26, 1, 0, 30);
    add_known(MODE_INIT,   10'd0,    6'd0,  1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 31);
    add_word(MODE_READ, 10'd12, 6'd0, 1'b0);
    add_known(MODE_WRITE,  10'd20,   6'd42, 1'b0, 6'd42, 1'b0, 1'b1, 1'b1, 31);
    add_word(MODE_READ, 10'd23, 6'd0, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.cfg_row) begin
        drain_results();
        set_slice_config(row.qp, row.tsel, row.intra, row.maxc);
      end else begin
        offer_word(row.mode, row.idx, row.st, row.nm, row.typed, row.want);
      end
    end
    drain_results();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph % 3)
        0:       begin tx_idle_pct = 9;  rx_idle_pct = 88; end
        1:       begin tx_idle_pct = 88; rx_idle_pct = 9;  end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      qp    = int'($urandom_range(127)) - 64;
      tsel  = $urandom_range(3);
      intra = ($urandom_range(99) < 30) ? 1 : 0;
      if (ph == 1) maxc = 1023;
      else if ($urandom_range(99) < 10) maxc = -1;
      else maxc = $urandom_range(60);
      set_slice_config(qp, tsel, intra, maxc);
      offer_word(MODE_INIT, 10'($urandom), 6'($urandom), 1'($urandom), 1'b0, none);
      for (int k = 1; k < PHASE_WORDS; k++) begin
        if (ph == 0 && k == 20) long_hold_req = 300;
        if (ph == 2 && k == 30) drain_results();
        pick = $urandom_range(99);
        if (pick < 6)       mode = MODE_INIT;
        else if (pick < 8)  mode = MODE_UNUSED;
        else if (pick < 52) mode = MODE_WRITE;
        else                mode = MODE_READ;
        pick = $urandom_range(99);
        if (pick < 75 && cur_size > 0) idx = 10'($urandom_range(cur_size - 1));
        else if (pick < 82 && cur_size < STORE_DEPTH) idx = 10'(cur_size);
        else idx = 10'($urandom);
        offer_word(mode, idx, 6'($urandom), 1'($urandom), 1'b0, none);
      end
      drain_results();
    end

    rx_idle_pct = 0;
    repeat (64) @(posedge clk_i);
    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
